[rtl/sogi_pkg.sv]
// shared constants, types and helper functions for the sogi-pll grid tracker
// used by every rtl file of the block; depends on nothing
`default_nettype none

package sogi_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int QUARTER_PTS = 1 << (SINE_TABLE_BITS - 2);
    localparam int ROM_W       = FRAC_BITS + 1;
    localparam int ROM_AW      = SINE_TABLE_BITS - 1;
    localparam int SIN_W       = FRAC_BITS + 2;

    localparam int OPD_W     = 65;
    localparam int PROD_W    = 128;
    localparam int RES_W     = 64;
    localparam int SHIFT_W   = 7;
    localparam int DEN_W     = 48;
    localparam int DVD_W     = 64 + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam int PERIOD_SHIFT = 33;
    localparam int PLL_DT_SHIFT = 32;
    localparam int RATIO_SHIFT  = 16;
    localparam int PHASE_LSB    = 64 + FRAC_BITS;

    localparam logic [127:0] MAG_CAP = 128'd1 << 62;
    localparam logic [63:0] INV_2PI_Q64 = 64'd2935890503282001226;
    localparam logic signed [63:0] HALF_PI_Q60 = 64'sd1811004864519280710;
    localparam logic [15:0] DEFAULT_RATIO = 16'd13107;

    localparam logic [31:0] NOMINAL_RESET = 32'd20588742;
    localparam logic [19:0] SOGI_GAIN_RESET = 20'd92682;
    localparam logic [31:0] PLL_GAIN_RESET = 32'd0;
    localparam logic [15:0] RATIO_RESET = 16'd0;
    localparam logic [31:0] PERIOD_RESET = 32'd429497;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_OMEGA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOGI_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLL_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_RATIO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd4;

    typedef enum logic [4:0] {
        OP_H, OP_HK, OP_HH, OP_M1, OP_M2, OP_M3, OP_M4, OP_DIV, OP_M5, OP_M6,
        OP_AR, OP_BR, OP_P1, OP_P2, OP_G, OP_T2, OP_LIM, OP_WD, OP_PH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic accept;
        logic mul_start;
        logic div_start;
        logic commit;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } status_t;

    typedef logic [ROM_W-1:0] rom_t [QUARTER_PTS+1];

    function automatic logic signed [65:0] sat_w(input logic signed [65:0] v, input int w);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = (66'sd1 <<< (w - 1)) - 66'sd1;
        lo = -hi - 66'sd1;
        if (v > hi)
            return hi;
        else if (v < lo)
            return lo;
        return v;
    endfunction

    // elaboration-time product with floor and magnitude cap
    function automatic logic signed [63:0] cmulq(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input int s);
        logic [127:0] p;
        logic signed [127:0] q;
        p = {{64{a[63]}}, a} * {{64{b[63]}}, b};
        q = $signed(p) >>> s;
        if (q > $signed(MAG_CAP))
            q = $signed(MAG_CAP);
        else if (q < -$signed(MAG_CAP))
            q = -$signed(MAG_CAP);
        return q[63:0];
    endfunction

    // quarter-wave sine by taylor series, evaluated once at elaboration
    function automatic rom_t build_rom();
        rom_t rom;
        logic signed [63:0] x;
        logic signed [63:0] x2;
        logic signed [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] rnd;
        for (int i = 0; i <= QUARTER_PTS; i++)
        begin
            x = cmulq(HALF_PI_Q60, 64'(i), SINE_TABLE_BITS - 2);
            x2 = cmulq(x, x, 60);
            term = x;
            sum = x;
            term = -(cmulq(term, x2, 60) / 64'sd6);   sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd20);  sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd42);  sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd72);  sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd110); sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd156); sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd210); sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd272); sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd342); sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd420); sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd506); sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd600); sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd702); sum = sum + term;
            term = -(cmulq(term, x2, 60) / 64'sd812); sum = sum + term;
            if (sum < 0)
                sum = 64'sd0;
            rnd = (64'(sum) + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
            rom[i] = rnd[ROM_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    function automatic logic signed [SIN_W-1:0] sine_at(input logic [SINE_TABLE_BITS-1:0] idx);
        logic [1:0] quad;
        logic [ROM_AW-1:0] r;
        logic [ROM_W-1:0] v;
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        r = {1'b0, idx[SINE_TABLE_BITS-3:0]};
        v = quad[0] ? SINE_ROM[ROM_AW'(QUARTER_PTS) - r] : SINE_ROM[r];
        return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

`default_nettype wire

[rtl/sogi_mul.sv]
// sequenced sign-magnitude multiplier: four 32x32 partial products, then floor shift and cap
// depends on sogi_pkg
`default_nettype none

module sogi_mul
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [sogi_pkg::OPD_W-1:0] a,
    input  wire logic signed [sogi_pkg::OPD_W-1:0] b,
    input  wire logic [sogi_pkg::SHIFT_W-1:0]      shift,
    output logic                                   done,
    output logic [sogi_pkg::PROD_W-1:0]            prod,
    output logic signed [sogi_pkg::RES_W-1:0]      res
);

    logic [63:0] ma_reg, mb_reg;
    logic        neg_reg;
    logic [sogi_pkg::SHIFT_W-1:0] shift_reg;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg;
    logic        busy_reg, fin_reg, done_reg;
    logic signed [63:0] res_reg, res_next;

    logic [64:0]  abs_a, abs_b;
    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] sh, mask, q, qc;
    logic         rem_nz;

    always_comb
    begin
        abs_a = a[64] ? 65'(-a) : 65'(a);
        abs_b = b[64] ? 65'(-b) : 65'(b);
        a_half = cnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        b_half = cnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp = a_half * b_half;
        case (cnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            2'd2:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        acc_next = acc_reg + pp_sh;

        sh = acc_reg >> shift_reg;
        mask = (128'd1 << shift_reg) - 128'd1;
        rem_nz = |(acc_reg & mask);
        q = sh + 128'(neg_reg & rem_nz);
        qc = (q > sogi_pkg::MAG_CAP) ? sogi_pkg::MAG_CAP : q;
        res_next = neg_reg ? -$signed(qc[63:0]) : $signed(qc[63:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            fin_reg  <= 1'b0;
            done_reg <= fin_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg    <= abs_a[63:0];
            mb_reg    <= abs_b[63:0];
            neg_reg   <= a[64] ^ b[64];
            shift_reg <= shift;
            acc_reg   <= 128'd0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
        if (fin_reg)
            res_reg <= res_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

[rtl/sogi_div.sv]
// radix-2 restoring divider: (|num| << FRAC_BITS) / den, truncated toward zero and capped
// depends on sogi_pkg
`default_nettype none

module sogi_div
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [sogi_pkg::OPD_W-1:0] num,
    input  wire logic [sogi_pkg::DEN_W-1:0]        den,
    output logic                                   done,
    output logic signed [sogi_pkg::RES_W-1:0]      res
);

    localparam int DW = sogi_pkg::DVD_W;
    localparam int NW = sogi_pkg::DEN_W;

    logic [DW-1:0] dvd_reg;
    logic [NW-1:0] rem_reg, den_reg;
    logic          neg_reg;
    logic [sogi_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic          busy_reg, done_reg;

    logic [64:0]   mag;
    logic [NW:0]   rem_sh;
    logic [NW+1:0] diff;
    logic          ge;
    logic [DW-1:0] q_cap, q;

    always_comb
    begin
        mag = num[64] ? 65'(-num) : 65'(num);
        rem_sh = {rem_reg, dvd_reg[DW-1]};
        diff = {1'b0, rem_sh} - {2'b0, den_reg};
        ge = !diff[NW+1];
        q_cap = DW'(sogi_pkg::MAG_CAP);
        q = (dvd_reg > q_cap) ? q_cap : dvd_reg;
        res = neg_reg ? -$signed(q[63:0]) : $signed(q[63:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= sogi_pkg::DIV_CNT_W'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == sogi_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {mag[63:0], {sogi_pkg::FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[64];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[NW-1:0] : rem_sh[NW-1:0];
            dvd_reg <= {dvd_reg[DW-2:0], ge};
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

[rtl/sogi_dp.sv]
// datapath: configuration, filter and pll state, operand selection, multiplier and divider
// depends on sogi_pkg, sogi_mul and sogi_div
`default_nettype none

module sogi_dp
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire sogi_pkg::cmd_t                          cmd,
    output sogi_pkg::status_t                            st,
    input  wire logic signed [sogi_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic                                    cfg_write,
    input  wire logic [sogi_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [31:0]                             cfg_data,
    output logic signed [31:0]                           alpha_out,
    output logic signed [31:0]                           beta_out,
    output logic signed [31:0]                           q_error,
    output logic [31:0]                                  frequency_out,
    output logic [31:0]                                  phase_out
);

    localparam int F = sogi_pkg::FRAC_BITS;
    localparam int SB = sogi_pkg::SINE_TABLE_BITS;

    // configuration
    logic [31:0] nominal_reg, pll_gain_reg, period_reg;
    logic [19:0] k_reg;
    logic [15:0] ratio_reg;

    // persistent state
    logic signed [47:0] alpha_acc_reg, beta_acc_reg, alpha_rate_reg, beta_rate_reg;
    logic signed [39:0] fi_reg;
    logic [31:0] phase_reg, omega_reg;

    // per-item working registers
    logic signed [sogi_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic [31:0] h_reg;
    logic [35:0] hk_reg;
    logic [47:0] denom_reg;
    logic [63:0] x_reg;
    logic signed [47:0] b1_reg, b2_reg;
    logic signed [64:0] num_reg;
    logic signed [63:0] t_reg, vq_reg;

    logic signed [64:0] mul_a, mul_b, vin;
    logic [sogi_pkg::SHIFT_W-1:0] mul_sh;
    logic mul_done, div_done;
    logic [127:0] prod;
    logic signed [63:0] mres, dres;

    logic [15:0] ratio;
    logic [SB-1:0] tidx, cidx;
    logic signed [sogi_pkg::SIN_W-1:0] sin_v, cos_v;
    logic signed [41:0] wsum;
    logic [31:0] w;
    logic signed [63:0] fi64;

    sogi_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .shift (mul_sh),
        .done  (mul_done),
        .prod  (prod),
        .res   (mres)
    );

    sogi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (denom_reg),
        .done  (div_done),
        .res   (dres)
    );

    assign st.mul_done = mul_done;
    assign st.div_done = div_done;

    always_comb
    begin
        vin = 65'(sample_reg) <<< F;
        ratio = (ratio_reg == 16'd0) ? sogi_pkg::DEFAULT_RATIO : ratio_reg;
        tidx = phase_reg[31 -: SB];
        cidx = tidx + SB'(sogi_pkg::QUARTER_PTS);
        sin_v = sogi_pkg::sine_at(tidx);
        cos_v = sogi_pkg::sine_at(cidx);
        wsum = $signed({10'd0, nominal_reg}) + 42'(fi_reg);
        if (wsum < 0)
            w = 32'd0;
        else if (wsum > $signed({10'd0, 32'hFFFF_FFFF}))
            w = 32'hFFFF_FFFF;
        else
            w = wsum[31:0];
        fi64 = 64'(fi_reg);
    end

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = sogi_pkg::SHIFT_W'(F);
        case (cmd.op)
            sogi_pkg::OP_H:
            begin
                mul_a  = 65'(omega_reg);
                mul_b  = 65'(period_reg);
                mul_sh = sogi_pkg::SHIFT_W'(sogi_pkg::PERIOD_SHIFT);
            end
            sogi_pkg::OP_HK:
            begin
                mul_a = 65'(h_reg);
                mul_b = 65'(k_reg);
            end
            sogi_pkg::OP_HH:
            begin
                mul_a = 65'(h_reg);
                mul_b = 65'(h_reg);
            end
            sogi_pkg::OP_M1:
            begin
                mul_a  = 65'(alpha_rate_reg);
                mul_b  = 65'(period_reg);
                mul_sh = sogi_pkg::SHIFT_W'(sogi_pkg::PERIOD_SHIFT);
            end
            sogi_pkg::OP_M2:
            begin
                mul_a = 65'(hk_reg);
                mul_b = vin;
            end
            sogi_pkg::OP_M3:
            begin
                mul_a  = 65'(beta_rate_reg);
                mul_b  = 65'(period_reg);
                mul_sh = sogi_pkg::SHIFT_W'(sogi_pkg::PERIOD_SHIFT);
            end
            sogi_pkg::OP_M4:
            begin
                mul_a = 65'(h_reg);
                mul_b = 65'(b2_reg);
            end
            sogi_pkg::OP_M5:
            begin
                mul_a = 65'(h_reg);
                mul_b = 65'(alpha_acc_reg);
            end
            sogi_pkg::OP_M6:
            begin
                mul_a = 65'(k_reg);
                mul_b = vin - 65'(alpha_acc_reg);
            end
            sogi_pkg::OP_AR:
            begin
                mul_a = 65'(omega_reg);
                mul_b = 65'(t_reg);
            end
            sogi_pkg::OP_BR:
            begin
                mul_a = 65'(omega_reg);
                mul_b = 65'(alpha_acc_reg);
            end
            sogi_pkg::OP_P1:
            begin
                mul_a = -65'(sin_v);
                mul_b = 65'(alpha_acc_reg);
            end
            sogi_pkg::OP_P2:
            begin
                mul_a = 65'(cos_v);
                mul_b = 65'(beta_acc_reg);
            end
            sogi_pkg::OP_G:
            begin
                mul_a = 65'(pll_gain_reg);
                mul_b = 65'(vq_reg);
            end
            sogi_pkg::OP_T2:
            begin
                mul_a  = 65'($signed(x_reg));
                mul_b  = 65'(period_reg);
                mul_sh = sogi_pkg::SHIFT_W'(sogi_pkg::PLL_DT_SHIFT);
            end
            sogi_pkg::OP_LIM:
            begin
                mul_a  = 65'(nominal_reg);
                mul_b  = 65'(ratio);
                mul_sh = sogi_pkg::SHIFT_W'(sogi_pkg::RATIO_SHIFT);
            end
            sogi_pkg::OP_WD:
            begin
                mul_a  = 65'(w);
                mul_b  = 65'(period_reg);
                mul_sh = '0;
            end
            sogi_pkg::OP_PH:
            begin
                mul_a  = 65'(x_reg);
                mul_b  = 65'(sogi_pkg::INV_2PI_Q64);
                mul_sh = '0;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // configuration and state that persists across samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_reg    <= sogi_pkg::NOMINAL_RESET;
            k_reg          <= sogi_pkg::SOGI_GAIN_RESET;
            pll_gain_reg   <= sogi_pkg::PLL_GAIN_RESET;
            ratio_reg      <= sogi_pkg::RATIO_RESET;
            period_reg     <= sogi_pkg::PERIOD_RESET;
            alpha_acc_reg  <= '0;
            beta_acc_reg   <= '0;
            alpha_rate_reg <= '0;
            beta_rate_reg  <= '0;
            fi_reg         <= '0;
            phase_reg      <= '0;
            omega_reg      <= sogi_pkg::NOMINAL_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    sogi_pkg::REG_NOMINAL_OMEGA: nominal_reg  <= cfg_data;
                    sogi_pkg::REG_SOGI_GAIN:     k_reg        <= cfg_data[19:0];
                    sogi_pkg::REG_PLL_GAIN:      pll_gain_reg <= cfg_data;
                    sogi_pkg::REG_LIMIT_RATIO:   ratio_reg    <= cfg_data[15:0];
                    sogi_pkg::REG_SAMPLE_PERIOD: period_reg   <= cfg_data;
                    default:                     ratio_reg    <= ratio_reg;
                endcase
            end
            if (cmd.commit)
            begin
                case (cmd.op)
                    sogi_pkg::OP_DIV:
                        alpha_acc_reg <= 48'(sogi_pkg::sat_w(66'(dres), 48));
                    sogi_pkg::OP_M5:
                        beta_acc_reg <= 48'(sogi_pkg::sat_w(66'(b2_reg) + 66'(mres), 48));
                    sogi_pkg::OP_AR:
                        alpha_rate_reg <= 48'(sogi_pkg::sat_w(66'(mres), 48));
                    sogi_pkg::OP_BR:
                        beta_rate_reg <= 48'(sogi_pkg::sat_w(66'(mres), 48));
                    sogi_pkg::OP_T2:
                        fi_reg <= 40'(sogi_pkg::sat_w(66'(fi_reg) + 66'(mres), 40));
                    sogi_pkg::OP_LIM:
                    begin
                        // integrator clamp to plus or minus the limit
                        if (fi64 > mres)
                            fi_reg <= mres[39:0];
                        else if (fi64 < -mres)
                            fi_reg <= 40'(-mres);
                    end
                    sogi_pkg::OP_WD:
                        omega_reg <= w;
                    sogi_pkg::OP_PH:
                        phase_reg <= phase_reg + prod[sogi_pkg::PHASE_LSB +: 32];
                    default:
                        phase_reg <= phase_reg;
                endcase
            end
        end
    end

    // per-item working registers and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            sample_reg <= sample;
        if (cmd.commit)
        begin
            case (cmd.op)
                sogi_pkg::OP_H:  h_reg <= mres[31:0];
                sogi_pkg::OP_HK: hk_reg <= mres[35:0];
                sogi_pkg::OP_HH:
                    denom_reg <= (48'd1 << F) + 48'(hk_reg) + mres[47:0];
                sogi_pkg::OP_M1: x_reg <= 64'(66'(alpha_acc_reg) + 66'(mres));
                sogi_pkg::OP_M2:
                    b1_reg <= 48'(sogi_pkg::sat_w(66'($signed(x_reg)) + 66'(mres), 48));
                sogi_pkg::OP_M3:
                    b2_reg <= 48'(sogi_pkg::sat_w(66'(beta_acc_reg) + 66'(mres), 48));
                sogi_pkg::OP_M4: num_reg <= 65'(b1_reg) - 65'(mres);
                sogi_pkg::OP_M6: t_reg <= mres - 64'(beta_acc_reg);
                sogi_pkg::OP_P1: vq_reg <= mres;
                sogi_pkg::OP_P2: vq_reg <= vq_reg + mres;
                sogi_pkg::OP_G:  x_reg <= mres;
                sogi_pkg::OP_WD: x_reg <= prod[63:0];
                default:         h_reg <= h_reg;
            endcase
        end
        if (cmd.finish)
        begin
            alpha_out     <= 32'(sogi_pkg::sat_w(66'(alpha_acc_reg), 32));
            beta_out      <= 32'(sogi_pkg::sat_w(66'(beta_acc_reg), 32));
            q_error       <= 32'(sogi_pkg::sat_w(66'(vq_reg), 32));
            frequency_out <= omega_reg;
            phase_out     <= phase_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/sogi_ctrl.sv]
// controller: sequences the multiply and divide steps of one sample and owns the handshakes
// depends on sogi_pkg
`default_nettype none

module sogi_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire sogi_pkg::status_t st,
    output sogi_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    sogi_pkg::op_t op_reg, op_next;
    logic out_valid_reg, out_valid_next;
    logic step_done;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.op         = op_reg;
        in_stall       = 1'b1;
        step_done      = (op_reg == sogi_pkg::OP_DIV) ? st.div_done : st.mul_done;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    op_next    = sogi_pkg::OP_H;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (op_reg == sogi_pkg::OP_DIV)
                    cmd.div_start = 1'b1;
                else
                    cmd.mul_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (step_done)
                begin
                    cmd.commit = 1'b1;
                    if (op_reg == sogi_pkg::OP_PH)
                        state_next = ST_FINISH;
                    else
                    begin
                        op_next    = sogi_pkg::op_t'(5'(op_reg) + 5'd1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FINISH:
            begin
                // result register free or emptied this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= sogi_pkg::OP_H;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/sogi_pll_grid_tracker.sv]
// sogi-pll grid tracker top level: controller plus datapath, one sample at a time
// each sample runs 18 multiplies on the shared 32x32 multiplier, four partial products each,
// and an 80-step divide, then the result load
// in_stall stays high from acceptance until the result is loaded, longer while out_stall
// holds the previous result
// reset: asynchronous, active low; registers to defaults, filter and pll state cleared
`default_nettype none

module sogi_pll_grid_tracker
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic signed [sogi_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [31:0]                           alpha_out,
    output logic signed [31:0]                           beta_out,
    output logic signed [31:0]                           q_error,
    output logic [31:0]                                  frequency_out,
    output logic [31:0]                                  phase_out,
    input  wire logic                                    cfg_write,
    input  wire logic [sogi_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [31:0]                             cfg_data
);

    sogi_pkg::cmd_t    cmd;
    sogi_pkg::status_t st;

    sogi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    sogi_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .sample        (sample),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .alpha_out     (alpha_out),
        .beta_out      (beta_out),
        .q_error       (q_error),
        .frequency_out (frequency_out),
        .phase_out     (phase_out)
    );

`ifndef ASSERT_OFF
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(st.mul_done && st.div_done))
        else $error("multiplier and divider finished together");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish))
        else $error("out_valid rose without a finished transaction");

    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_start || cmd.div_start) |-> in_stall)
        else $error("input open while a step is issued");
`endif

endmodule

`default_nettype wire
